// File: rtl/rotary_position_embedding_defines.svh
// Assertion macros for the rotary position embedding block.
// Used by the top level; expects aclk and aresetn in the scope of each use.
`ifndef ROTARY_POSITION_EMBEDDING_DEFINES_SVH
`define ROTARY_POSITION_EMBEDDING_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge out of reset.
`define ROPE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rope: same-cycle check failed");
// Next-cycle implication, checked at every clock edge out of reset.
`define ROPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rope: next-cycle check failed");
`else
`define ROPE_ASSERT_SAME(lbl, ante, cons)
`define ROPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/rope_pkg.sv
// Shared types and constants of the rotary position embedding block.
// No dependencies; imported by rope_rotate and rotary_position_embedding.
`default_nettype none
package rope_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int HALF_DIM      = 64;
    localparam int TABLE_DEPTH   = MAX_POSITIONS * HALF_DIM;
    localparam int ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int TLEN_W = 11;
    localparam int POS_W  = 16;
    localparam int PAIR_W = 6;
    localparam int DATA_W = 16;

    localparam logic [TLEN_W-1:0] TLEN_RESET = TLEN_W'(1024);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_APPLY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [POS_W-1:0]         position;
        logic [PAIR_W-1:0]        pair_index;
        logic signed [DATA_W-1:0] first_value;
        logic signed [DATA_W-1:0] second_value;
        logic signed [DATA_W-1:0] sine_value;
        logic signed [DATA_W-1:0] cosine_value;
    } rope_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] rotated_first;
        logic signed [DATA_W-1:0] rotated_second;
        logic                     status;
    } rope_out_t;

    // Per-stage load enables of the arithmetic pipeline.
    typedef struct packed {
        logic load_mul;
        logic load_out;
    } rope_adv_t;

endpackage
`default_nettype wire

// File: rtl/rope_rotate.sv
// Multiply and round/saturate stages of the rotation datapath.
// Depends on rope_pkg for data types and the stage enable struct.
`default_nettype none
module rope_rotate (
    input  logic                              aclk,
    input  rope_pkg::rope_adv_t               adv,
    input  logic signed [rope_pkg::DATA_W-1:0] first_value,
    input  logic signed [rope_pkg::DATA_W-1:0] second_value,
    input  logic signed [rope_pkg::DATA_W-1:0] sine_value,
    input  logic signed [rope_pkg::DATA_W-1:0] cosine_value,
    input  logic                              status,
    output rope_pkg::rope_out_t               result
);
    import rope_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int FRAC_W = 14;
    localparam int SHR_W  = SUM_W - FRAC_W;

    // Round half up, floor-shift by the fraction width, saturate to 16 bits.
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] biased;
        logic signed [SHR_W-1:0] shifted;
        logic signed [SHR_W-1:0] max_val;
        logic signed [SHR_W-1:0] min_val;
        biased  = sum + SUM_W'(1 << (FRAC_W - 1));
        shifted = SHR_W'(biased >>> FRAC_W);
        max_val = SHR_W'((1 << (DATA_W - 1)) - 1);
        min_val = -SHR_W'(1 << (DATA_W - 1));
        if (shifted > max_val) begin
            return max_val[DATA_W-1:0];
        end else if (shifted < min_val) begin
            return min_val[DATA_W-1:0];
        end else begin
            return shifted[DATA_W-1:0];
        end
    endfunction

    logic signed [PROD_W-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic                     status_reg;
    rope_out_t                result_reg;
    logic signed [SUM_W-1:0]  sum_first, sum_second;

    always_ff @(posedge aclk) begin
        if (adv.load_mul) begin
            ac_reg     <= first_value * cosine_value;
            bs_reg     <= second_value * sine_value;
            as_reg     <= first_value * sine_value;
            bc_reg     <= second_value * cosine_value;
            status_reg <= status;
        end
    end

    assign sum_first  = SUM_W'(ac_reg) - SUM_W'(bs_reg);
    assign sum_second = SUM_W'(as_reg) + SUM_W'(bc_reg);

    always_ff @(posedge aclk) begin
        if (adv.load_out) begin
            result_reg.rotated_first  <= round_sat(sum_first);
            result_reg.rotated_second <= round_sat(sum_second);
            result_reg.status         <= status_reg;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

// File: rtl/rotary_position_embedding.sv
// Top level of the rotary position embedding block: table memory and handshake.
// Depends on rope_pkg, rope_rotate and rotary_position_embedding_defines.svh.
//
// Usage: items enter on s_valid/s_ready with s_data and leave on m_valid/m_ready
// with m_data; every item gives exactly one result item, in order. A write item
// (kind 0) stores a sine/cosine entry at (position, pair_index) and returns zeros.
// An apply item (kind 1) rotates (first_value, second_value) by the stored entry;
// a position at or beyond table_length, or outside storage, gives status 1 and
// zero values. table_length is written on cfg_valid/cfg_ready/cfg_data while
// the block is idle; cfg_ready is always high.
// From acceptance to m_valid an item passes the table read, four 16x16
// multiplies, then sum/round/saturate. Throughput is one item per cycle while
// m_ready stays high; the registered table read and the multiplier bank set the
// stage split. Reset clears the valid bits and sets table_length to 1024; the
// table itself holds nothing defined until entries are written, so no clearing
// pass runs. When the receiver stalls, results pile up in the three stages,
// and s_ready drops only once every stage holds an item.
`default_nettype none
`include "rotary_position_embedding_defines.svh"
module rotary_position_embedding (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rope_pkg::TLEN_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rope_pkg::rope_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rope_pkg::rope_out_t           m_data
);
    import rope_pkg::*;

    localparam int POS_CMP_W  = POS_W + 1;
    localparam int PAIR_CMP_W = 10;

    logic [TLEN_W-1:0] table_length_reg;

    // Stage valid bits: s1 holds the table read, s2 the products, s3 the result.
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    logic accept;
    rope_adv_t adv;

    logic               in_store;
    logic               range_err;
    logic [ADDR_W-1:0]  addr;

    logic [2*DATA_W-1:0]        rot_mem [TABLE_DEPTH];
    logic [2*DATA_W-1:0]        rd_data_reg;
    logic signed [DATA_W-1:0]   s1_first_reg, s1_second_reg;
    logic                       s1_status_reg;
    logic                       s1_zero_reg;
    logic signed [DATA_W-1:0]   sine_sel, cosine_sel;

    // Config register; the user writes only while the pipeline is idle, unchecked.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= TLEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            table_length_reg <= cfg_data;
        end
    end

    // Each stage moves forward when the stage after it is empty or moving.
    assign en3    = !v3_reg || m_ready;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign s_ready = en1;
    assign accept = s_valid && s_ready;
    assign adv.load_mul = en2;
    assign adv.load_out = en3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Table address and range checks on the incoming item.
    assign in_store = (POS_CMP_W'(s_data.position) < POS_CMP_W'(MAX_POSITIONS))
                   && (PAIR_CMP_W'(s_data.pair_index) < PAIR_CMP_W'(HALF_DIM));
    assign addr = ADDR_W'(ADDR_W'(s_data.position) * ADDR_W'(HALF_DIM))
                + ADDR_W'(s_data.pair_index);
    assign range_err = !in_store
                    || (s_data.position >= POS_W'(table_length_reg));

    // Writes and reads both happen at acceptance, so item order is kept.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (s_data.kind == KIND_WRITE) begin
                if (in_store) begin
                    rot_mem[addr] <= {s_data.sine_value, s_data.cosine_value};
                end
            end else begin
                rd_data_reg <= rot_mem[addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_first_reg  <= s_data.first_value;
            s1_second_reg <= s_data.second_value;
            s1_status_reg <= (s_data.kind == KIND_APPLY) && range_err ? STATUS_RANGE
                                                                      : STATUS_OK;
            s1_zero_reg   <= (s_data.kind == KIND_WRITE) || range_err;
        end
    end

    // Zeroed sine and cosine make both products, and so both outputs, zero.
    assign sine_sel   = s1_zero_reg ? '0 : rd_data_reg[2*DATA_W-1:DATA_W];
    assign cosine_sel = s1_zero_reg ? '0 : rd_data_reg[DATA_W-1:0];

    rope_rotate u_rotate (
        .aclk         (aclk),
        .adv          (adv),
        .first_value  (s1_first_reg),
        .second_value (s1_second_reg),
        .sine_value   (sine_sel),
        .cosine_value (cosine_sel),
        .status       (s1_status_reg),
        .result       (m_data)
    );

    assign m_valid = v3_reg;

    // A bubble anywhere in the pipeline must leave room for a new item.
    `ROPE_ASSERT_SAME(a_ready_on_bubble, (!v1_reg || !v2_reg || !v3_reg), s_ready)
    // A range error result carries zero values.
    `ROPE_ASSERT_SAME(a_err_zero, (m_valid && m_data.status == STATUS_RANGE),
        (m_data.rotated_first == '0 && m_data.rotated_second == '0))
    // An item in the product stage is never dropped while the output is blocked.
    `ROPE_ASSERT_NEXT(a_s2_hold, (v2_reg && !en3), v2_reg)

endmodule
`default_nettype wire

// File: tb/rotation_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the rotary position embedding testbench: an untimed predictor
// of the block and the queue of rotation results it still owes.
// Depends on rope_pkg for the item types, widths and codes.
package rotation_scoreboard_pkg;
    import rope_pkg::*;

    class rotation_scoreboard;
        // Sine in the upper half of each entry, cosine in the lower half.
        bit [31:0]         sincos_store [TABLE_DEPTH];
        logic [TLEN_W-1:0] length_reg;
        rope_out_t         expected_rotations [$];
        int                mismatches;

        function new();
            length_reg = TLEN_RESET;
            mismatches = 0;
        endfunction

        function void set_length(logic [TLEN_W-1:0] value);
            length_reg = value;
        endfunction

        // Round half up, floor-shift by 14 and clamp to the signed 16-bit range.
        static function logic signed [DATA_W-1:0] round_saturate(longint sum);
            longint r;
            r = (sum + 64'sd8192) >>> 14;
            if (r > 32767)
                r = 32767;
            else if (r < -32768)
                r = -32768;
            return DATA_W'(r);
        endfunction

        // Works out the result of one item; a write inside storage also updates the store.
        function rope_out_t rotate_pair(rope_in_t item);
            rope_out_t                res;
            int                       addr;
            logic signed [DATA_W-1:0] sine;
            logic signed [DATA_W-1:0] cosine;
            longint                   a;
            longint                   b;
            longint                   s;
            longint                   c;
            res = '0;
            res.status = STATUS_OK;
            addr = int'(item.position) * HALF_DIM + int'(item.pair_index);
            if (item.kind == KIND_WRITE) begin
                if (item.position < MAX_POSITIONS)
                    sincos_store[addr] = {item.sine_value, item.cosine_value};
            end else if (item.position >= MAX_POSITIONS || item.position >= length_reg) begin
                res.status = STATUS_RANGE;
            end else begin
                {sine, cosine} = sincos_store[addr];
                a = $signed(item.first_value);
                b = $signed(item.second_value);
                s = sine;
                c = cosine;
                res.rotated_first  = round_saturate(a * c - b * s);
                res.rotated_second = round_saturate(a * s + b * c);
            end
            return res;
        endfunction

        function void note_item(rope_in_t item);
            expected_rotations.push_back(rotate_pair(item));
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(rope_out_t got);
            rope_out_t want;
            if (expected_rotations.size() == 0) begin
                report($sformatf("%0t: unexpected result first %0d second %0d status %0d",
                                 $time, got.rotated_first, got.rotated_second, got.status));
                return;
            end
            want = expected_rotations.pop_front();
            if (got.rotated_first !== want.rotated_first ||
                got.rotated_second !== want.rotated_second ||
                got.status !== want.status)
                report($sformatf({"%0t: mismatch, expected first %0d second %0d status %0d,",
                                  " got first %0d second %0d status %0d"},
                                 $time, want.rotated_first, want.rotated_second, want.status,
                                 got.rotated_first, got.rotated_second, got.status));
        endfunction

        function int pending();
            return expected_rotations.size();
        endfunction

        function bit clean();
            return mismatches == 0 && expected_rotations.size() == 0;
        endfunction
    endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of rotary_position_embedding: directed corner items,
// then random phases under several table lengths and idling patterns.
// Depends on rope_pkg and rotation_scoreboard_pkg.
module tb_top;
    import rope_pkg::*;
    import rotation_scoreboard_pkg::*;

    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 190;
    localparam int PHASES           = 6;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [TLEN_W-1:0] cfg_data  = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    rope_in_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    rope_out_t         m_data;

    rotation_scoreboard rotation_sb;

    // Generator-side view: the length in force and which entries hold data,
    // so that no apply item ever reads an entry that was never written.
    logic [TLEN_W-1:0] cur_length = TLEN_RESET;
    bit                entry_written [TABLE_DEPTH];
    int                written_addrs [$];
    int                send_idle_pct = 10;
    int                recv_idle_pct = 71;
    int                stall_cycles  = 0;

    rotary_position_embedding dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // All handshakes are observed here, at the rising edge, together with the
    // watchdog that ends a run in which nothing moves any more.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                rotation_sb.set_length(cfg_data);
            if (s_valid && s_ready)
                rotation_sb.note_item(s_data);
            if (m_valid && m_ready)
                rotation_sb.check_result(m_data);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles == STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic rope_in_t make_write(logic [POS_W-1:0] pos, logic [PAIR_W-1:0] pair,
                                            logic signed [DATA_W-1:0] sine,
                                            logic signed [DATA_W-1:0] cosine);
        rope_in_t item;
        item.kind         = KIND_WRITE;
        item.position     = pos;
        item.pair_index   = pair;
        item.first_value  = DATA_W'($urandom());
        item.second_value = DATA_W'($urandom());
        item.sine_value   = sine;
        item.cosine_value = cosine;
        return item;
    endfunction

    function automatic rope_in_t make_apply(logic [POS_W-1:0] pos, logic [PAIR_W-1:0] pair,
                                            logic signed [DATA_W-1:0] a,
                                            logic signed [DATA_W-1:0] b);
        rope_in_t item;
        item.kind         = KIND_APPLY;
        item.position     = pos;
        item.pair_index   = pair;
        item.first_value  = a;
        item.second_value = b;
        item.sine_value   = DATA_W'($urandom());
        item.cosine_value = DATA_W'($urandom());
        return item;
    endfunction

    // Mostly proper Q2.14 values in [-1, 1], sometimes any 16-bit pattern.
    function automatic logic signed [DATA_W-1:0] pick_trig();
        int v;
        if ($urandom_range(0, 9) < 8)
            v = int'($urandom_range(0, 32768)) - 16384;
        else
            v = $urandom();
        return DATA_W'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return 16'sd32767;
            1: return -16'sd32768;
            2: return 16'sd0;
            3: return 16'sd1;
            4: return -16'sd1;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue(input rope_in_t item);
        int addr;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        if (item.kind == KIND_WRITE && item.position < MAX_POSITIONS) begin
            addr = int'(item.position) * HALF_DIM + int'(item.pair_index);
            if (!entry_written[addr]) begin
                entry_written[addr] = 1'b1;
                written_addrs.push_back(addr);
            end
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Holds the sender off until every result owed has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (rotation_sb.pending() != 0);
    endtask

    task automatic set_table_length(input logic [TLEN_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid  <= 1'b0;
        cur_length = value;
    endtask

    // Most items are writes inside storage or applies on written entries;
    // the rest are applies and writes with any 16-bit position.
    task automatic pick_random_item(output rope_in_t item, output bit counts);
        int               roll;
        int               lim;
        int               addr;
        logic [POS_W-1:0] pos;
        roll   = $urandom_range(0, 99);
        lim    = (cur_length == 0 || cur_length > MAX_POSITIONS) ? MAX_POSITIONS
                                                                  : int'(cur_length);
        counts = 1'b1;
        if (roll >= 30 && roll < 85 && written_addrs.size() == 0)
            roll = 0;
        if (roll < 30) begin
            if ($urandom_range(0, 9) < 7)
                pos = POS_W'($urandom_range(0, lim - 1));
            else
                pos = POS_W'($urandom_range(0, MAX_POSITIONS - 1));
            item = make_write(pos, PAIR_W'($urandom_range(0, HALF_DIM - 1)),
                              pick_trig(), pick_trig());
        end else if (roll < 85) begin
            addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            for (int t = 0; t < 3 && addr / HALF_DIM >= cur_length; t++)
                addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            item = make_apply(POS_W'(addr / HALF_DIM), PAIR_W'(addr % HALF_DIM),
                              pick_sample(), pick_sample());
        end else if (roll < 93) begin
            item = make_apply(POS_W'($urandom_range(0, 65535)),
                              PAIR_W'($urandom_range(0, HALF_DIM - 1)),
                              pick_sample(), pick_sample());
            // An in-range read of an empty entry is pushed far out of range.
            if (item.position < cur_length && item.position < MAX_POSITIONS &&
                !entry_written[int'(item.position) * HALF_DIM + int'(item.pair_index)])
                item.position[POS_W-1] = 1'b1;
        end else begin
            item = make_write(POS_W'($urandom_range(0, 65535)),
                              PAIR_W'($urandom_range(0, HALF_DIM - 1)),
                              pick_trig(), pick_trig());
            counts = (item.position < MAX_POSITIONS);
        end
    endtask

    initial begin
        rope_in_t          item;
        bit                counts;
        int                counted;
        int                mode;
        logic [TLEN_W-1:0] phase_len [PHASES];

        rotation_sb = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset length: corner entries, full-scale and
        // saturating samples, the half-way rounding case, writes outside
        // storage (ignored) and applies past the end of the table.
        issue(make_write(0, 0, 0, 16384));
        issue(make_write(MAX_POSITIONS - 1, HALF_DIM - 1, 16384, -16384));
        issue(make_write(5, 7, -16384, 0));
        issue(make_write(6, 1, -32768, 32767));
        issue(make_write(2, 3, 0, 8192));
        issue(make_write(MAX_POSITIONS, 0, 16384, 16384));
        issue(make_write(65535, HALF_DIM - 1, -16384, -16384));
        issue(make_apply(0, 0, 32767, -32768));
        issue(make_apply(MAX_POSITIONS - 1, HALF_DIM - 1, -32768, -32768));
        issue(make_apply(5, 7, 32767, 32767));
        issue(make_apply(6, 1, -32768, 32767));
        issue(make_apply(2, 3, 1, -1));
        issue(make_apply(2, 3, -1, 1));
        issue(make_apply(0, 0, 0, 0));
        issue(make_apply(MAX_POSITIONS, 0, 100, 200));
        issue(make_apply(65535, HALF_DIM - 1, -5, 5));

        // Shortest table: only position 0 is in range, writes beyond it stick.
        set_table_length(1);
        issue(make_apply(0, 0, 12345, -12345));
        issue(make_apply(1, 0, 7, 7));
        issue(make_apply(MAX_POSITIONS - 1, HALF_DIM - 1, 1, 1));
        issue(make_write(3, 3, 11585, 11585));

        // Zero length rejects every apply; the largest length admits all storage.
        set_table_length(0);
        issue(make_apply(0, 0, 1000, 1000));
        set_table_length(2047);
        issue(make_apply(MAX_POSITIONS - 1, HALF_DIM - 1, 20000, -20000));
        issue(make_apply(MAX_POSITIONS, 0, 1, 1));
        issue(make_apply(3, 3, 32767, 32767));

        phase_len[0] = 2047;
        phase_len[1] = TLEN_W'($urandom_range(1, MAX_POSITIONS - 1));
        phase_len[2] = 0;
        phase_len[3] = TLEN_RESET;
        phase_len[4] = 1;
        phase_len[5] = TLEN_W'($urandom_range(2, 2047));

        // Two phases per idling pattern: sender light and receiver heavy,
        // then the reverse, then no idling on either side.
        for (int p = 0; p < PHASES; p++) begin
            mode = p / 2;
            send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 71 : 0;
            recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 10 : 0;
            set_table_length(phase_len[p]);
            counted = 0;
            while (counted < RANDOM_PER_PHASE) begin
                pick_random_item(item, counts);
                issue(item);
                if (counts)
                    counted++;
                if ($urandom_range(0, 199) == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (rotation_sb.clean())
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/rope_pkg.sv
rtl/rope_rotate.sv
rtl/rotary_position_embedding.sv
tb/rotation_scoreboard_pkg.sv
tb/tb_top.sv
